### hdl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sem_pkg;

	localparam int FRAME_WIDTH_BITS  = 11;
	localparam int FRAME_HEIGHT_BITS = 16;
	localparam int ROW_BITS          = 17;
	localparam int PIX_BITS          = 24;
	localparam int SUM_BITS          = 21;
	localparam int GRAD_BITS         = 11;

	localparam logic       CFG_FRAME_WIDTH  = 1'b0;
	localparam logic       CFG_FRAME_HEIGHT = 1'b1;
	localparam logic       ACT_PIXEL        = 1'b0;
	localparam logic       ACT_DRAIN        = 1'b1;

	localparam logic [FRAME_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [FRAME_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;
	localparam logic [SUM_BITS-1:0]          MAG_CLAMP_SUM = 21'd65281;
	localparam logic [7:0]                   MAG_MAX       = 8'd255;
	localparam logic [2:0]                   ROOT_LAST     = 3'd7;

	typedef struct packed {
		logic       accept;
		logic       index;
		logic       read;
		logic       sum;
		logic       square;
		logic       root_step;
		logic [2:0] root_bit;
		logic       emit;
	} sem_cmd_t;

	typedef struct packed {
		logic drain_ignore;
		logic result_due;
		logic out_free;
	} sem_sts_t;

endpackage

### hdl/sem_ram.sv
// Generic simple dual-port RAM with registered read.
// Standalone; used for the two row stores.
module sem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/sem_ctrl.sv
// Sequencer for the Sobel edge magnitude block.
// Depends on sem_pkg; drives the datapath through sem_cmd_t.
module sem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sem_pkg::sem_sts_t sts,
	output sem_pkg::sem_cmd_t cmd,
	output logic              busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INDEX,
		ST_READ,
		ST_SUM,
		ST_SQUARE,
		ST_ROOT,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [2:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_INDEX;
				end
				ST_INDEX: begin
					state_q <= sts.drain_ignore ? ST_IDLE : ST_READ;
				end
				ST_READ: begin
					state_q <= sts.result_due ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					step_q  <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (step_q == sem_pkg::ROOT_LAST) state_q <= ST_EMIT;
					step_q <= step_q + 3'd1;
				end
				ST_EMIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.index     = (state_q == ST_INDEX);
		cmd.read      = (state_q == ST_READ);
		cmd.sum       = (state_q == ST_SUM);
		cmd.square    = (state_q == ST_SQUARE);
		cmd.root_step = (state_q == ST_ROOT);
		cmd.root_bit  = step_q;
		cmd.emit      = (state_q == ST_EMIT) && sts.out_free;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### hdl/sem_datapath.sv
// Datapath: row stores, 3x3 window, raster counters, gradients and square root.
// Depends on sem_pkg and sem_ram; sequenced by sem_ctrl.
module sem_datapath #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sem_pkg::sem_cmd_t cmd,
	output sem_pkg::sem_sts_t sts,
	input  logic              action,
	input  logic [7:0]        red_in,
	input  logic [7:0]        green_in,
	input  logic [7:0]        blue_in,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        red_edge,
	output logic [7:0]        green_edge,
	output logic [7:0]        blue_edge,
	output logic              frame_end
);

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int FW    = sem_pkg::FRAME_WIDTH_BITS;
	localparam int CMPW  = (WW > FW) ? WW : FW;
	localparam int RB    = sem_pkg::ROW_BITS;
	localparam int IDXW  = RB + WW + 1;
	localparam int PB    = sem_pkg::PIX_BITS;
	localparam int SB    = sem_pkg::SUM_BITS;
	localparam int GB    = sem_pkg::GRAD_BITS;

	logic [FW-1:0]                          fw_q;
	logic [sem_pkg::FRAME_HEIGHT_BITS-1:0]  fh_q;
	logic                                   action_q;
	logic [PB-1:0]                          pix_q;
	logic [CW-1:0]                          in_col_q, out_col_q;
	logic [RB-1:0]                          in_row_q, out_row_q;
	logic [PB-1:0]                          win_q [9];
	logic [IDXW-1:0]                        in_idx_s1, out_idx_s1;
	logic signed [GB-1:0]                   gx_s2 [3];
	logic signed [GB-1:0]                   gy_s2 [3];
	logic                                   last_s2;
	logic [SB-1:0]                          sum_q [3];
	logic [7:0]                             root_q [3];
	logic                                   out_valid_q;
	logic [7:0]                             edge_q [3];
	logic                                   frame_end_q;

	logic [CMPW-1:0]                        fw_ext;
	logic [WW-1:0]                          eff_w;
	logic [sem_pkg::FRAME_HEIGHT_BITS-1:0]  eff_h;
	logic                                   in_frame;
	logic [PB-1:0]                          pix_eff;
	logic [PB-1:0]                          upper_rd, middle_rd;
	logic                                   store_we;
	logic                                   col_wrap;
	logic                                   mask_top, mask_bot, mask_left, mask_right;
	logic [7:0]                             bit_mask;
	logic signed [GB-1:0]                   gx_c [3];
	logic signed [GB-1:0]                   gy_c [3];

	always_comb begin
		fw_ext = CMPW'(fw_q);
		if (fw_ext == '0) begin
			eff_w = WW'(1);
		end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(fw_ext);
		end
		eff_h = (fh_q == '0) ? 16'd1 : fh_q;
	end

	assign in_frame = in_row_q < RB'(eff_h);
	assign pix_eff  = in_frame ? pix_q : '0;
	assign store_we = cmd.read && in_frame;
	assign col_wrap = ((WW+1)'(in_col_q) + (WW+1)'(1)) >= (WW+1)'(eff_w);

	assign sts.drain_ignore = (action_q == sem_pkg::ACT_DRAIN) && in_frame;
	assign sts.result_due   = in_idx_s1 >= (out_idx_s1 + IDXW'(eff_w) + IDXW'(1));
	assign sts.out_free     = !out_valid_q || !out_stall;

	sem_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (store_we),
		.waddr (in_col_q),
		.wdata (middle_rd),
		.raddr (in_col_q),
		.rdata (upper_rd)
	);

	sem_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (store_we),
		.waddr (in_col_q),
		.wdata (pix_q),
		.raddr (in_col_q),
		.rdata (middle_rd)
	);

	// Border masks for the pixel whose result is next.
	assign mask_top   = (out_row_q == '0);
	assign mask_bot   = ((RB+1)'(out_row_q) + (RB+1)'(1)) >= (RB+1)'(eff_h);
	assign mask_left  = (out_col_q == '0);
	assign mask_right = ((WW+1)'(out_col_q) + (WW+1)'(1)) >= (WW+1)'(eff_w);

	always_comb begin
		logic [7:0] p [9];
		logic [9:0] xpos, xneg, ypos, yneg;
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++) begin
				p[i] = win_q[i][PB-1-8*ch -: 8];
				if ((i < 3 && mask_top) || (i > 5 && mask_bot) ||
				    ((i % 3) == 0 && mask_left) || ((i % 3) == 2 && mask_right)) begin
					p[i] = '0;
				end
			end
			xpos = 10'(p[2]) + {1'b0, p[5], 1'b0} + 10'(p[8]);
			xneg = 10'(p[0]) + {1'b0, p[3], 1'b0} + 10'(p[6]);
			ypos = 10'(p[6]) + {1'b0, p[7], 1'b0} + 10'(p[8]);
			yneg = 10'(p[0]) + {1'b0, p[1], 1'b0} + 10'(p[2]);
			gx_c[ch] = $signed(GB'(xpos)) - $signed(GB'(xneg));
			gy_c[ch] = $signed(GB'(ypos)) - $signed(GB'(yneg));
		end
	end

	assign bit_mask = 8'h80 >> cmd.root_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= sem_pkg::WIDTH_RESET;
			fh_q      <= sem_pkg::HEIGHT_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					sem_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_data[FW-1:0];
					sem_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.read) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= upper_rd;
				win_q[5] <= middle_rd;
				win_q[8] <= pix_eff;
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RB'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				if (last_s2) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (mask_right) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RB'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers; no reset needed.
	always_ff @(posedge clk) begin
		logic [7:0]  t;
		logic [16:0] test;
		if (cmd.accept) begin
			action_q <= action;
			pix_q    <= {red_in, green_in, blue_in};
		end
		if (cmd.index) begin
			in_idx_s1  <= IDXW'(in_row_q) * IDXW'(eff_w) + IDXW'(in_col_q);
			out_idx_s1 <= IDXW'(out_row_q) * IDXW'(eff_w) + IDXW'(out_col_q);
		end
		if (cmd.sum) begin
			gx_s2   <= gx_c;
			gy_s2   <= gy_c;
			last_s2 <= mask_bot && mask_right;
		end
		if (cmd.square) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_q[ch]  <= SB'(gx_s2[ch] * gx_s2[ch]) + SB'(gy_s2[ch] * gy_s2[ch]);
				root_q[ch] <= '0;
			end
		end
		// One bit of the rounded root per step: keep t if t*t - t + 1 fits.
		if (cmd.root_step) begin
			for (int ch = 0; ch < 3; ch++) begin
				t    = root_q[ch] | bit_mask;
				test = 17'(t) * 17'(t) - 17'(t) + 17'd1;
				if (SB'(test) <= sum_q[ch]) root_q[ch] <= t;
			end
		end
		if (cmd.emit) begin
			for (int ch = 0; ch < 3; ch++) begin
				edge_q[ch] <= (sum_q[ch] >= sem_pkg::MAG_CLAMP_SUM) ? sem_pkg::MAG_MAX
				                                                     : root_q[ch];
			end
			frame_end_q <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign red_edge   = edge_q[0];
	assign green_edge = edge_q[1];
	assign blue_edge  = edge_q[2];
	assign frame_end  = frame_end_q;

endmodule

### hdl/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude filter.
// Depends on sem_pkg, sem_ctrl and sem_datapath.
//
// Pixels enter in raster order; each result leaves one row plus one pixel after
// its pixel, so after the frame's last pixel the source sends drain beats
// (action = 1) to release the remaining results. Items are handled one at a
// time: a beat that yields no result passes the index and read states (only
// index for a drain beat ignored inside the frame), one that yields a result
// also sum, square, root and emit; root runs the shared eight-step square-root
// iteration on all three channels at once. A finished result sits in the output
// register, so the next beat is taken while it waits. Configuration writes are
// always ready and belong between frames or while the block is idle.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_edge,
	output logic [7:0]  green_edge,
	output logic [7:0]  blue_edge,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	sem_pkg::sem_cmd_t cmd;
	sem_pkg::sem_sts_t sts;
	logic              busy;

	assign in_stall  = busy;
	assign cfg_ready = 1'b1;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.cfg_write  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.red_edge   (red_edge),
		.green_edge (green_edge),
		.blue_edge  (blue_edge),
		.frame_end  (frame_end)
	);

endmodule

### hdl/sem_checker.sv
// Port-level checker for sobel_edge_magnitude_rgb, attached by bind.
// Depends only on the top level's ports.
module sem_port_assert (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red_edge,
	input logic [7:0] green_edge,
	input logic [7:0] blue_edge,
	input logic       frame_end
);

	// Every accepted beat keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// A new result only appears at the end of work on an item.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output beat dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(red_edge) && $stable(green_edge) &&
		$stable(blue_edge) && $stable(frame_end)))
		else $error("stalled output beat changed");

endmodule

bind sobel_edge_magnitude_rgb sem_port_assert u_sem_port_assert (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.red_edge   (red_edge),
	.green_edge (green_edge),
	.blue_edge  (blue_edge),
	.frame_end  (frame_end)
);
